// ===== sv/swmax_pkg.sv =====
// -----------------------------------------------------------------------------
// Sliding window maximum: shared definitions
// Default sizes, window register format and the command word that the
// controller broadcasts to every cell of the candidate chain.
// -----------------------------------------------------------------------------
package swmax_pkg;

   localparam int MAX_WINDOW_DEFAULT  = 64;
   localparam int SAMPLE_BITS_DEFAULT = 32;

   // Window size register
   localparam int              WINDOW_BITS  = 7;
   localparam logic [6:0]      WINDOW_RESET = 7'd1;

   // Broadcast command: step takes the pending sample, shift moves every
   // entry one cell toward the head, restart empties the chain but for the new sample.
   typedef struct packed {
      logic step;
      logic shift;
      logic restart;
   } cell_cmd_type;

endpackage

// ===== sv/swmax_cell.sv =====
// -----------------------------------------------------------------------------
// Sliding window maximum: candidate cell
// One deque slot. Holds a candidate value and its age, decides locally
// whether it survives the next sample and takes its successor's entry or
// the new sample from the neighbors.
// -----------------------------------------------------------------------------
module swmax_cell #(
   parameter int SAMPLE_BITS = swmax_pkg::SAMPLE_BITS_DEFAULT,
   parameter int AGE_BITS    = 6,
   parameter bit HEAD        = 1'b0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  swmax_pkg::cell_cmd_type   cmd,
   input  logic [SAMPLE_BITS-1:0]    new_value,
   input  logic [AGE_BITS-1:0]       stale_age,
   input  logic                      up_valid,
   input  logic                      up_keep,
   input  logic [SAMPLE_BITS-1:0]    up_value,
   input  logic [AGE_BITS-1:0]       up_age,
   input  logic                      down_keep,
   output logic                      valid,
   output logic [SAMPLE_BITS-1:0]    value,
   output logic [AGE_BITS-1:0]       age,
   output logic                      keep,
   output logic                      stale
);
   import swmax_pkg::*;

   logic                   valid_ff, valid_in;
   logic [SAMPLE_BITS-1:0] value_ff, value_in;
   logic [AGE_BITS-1:0]    age_ff, age_in;

   logic                   src_keep;
   logic [SAMPLE_BITS-1:0] src_value;
   logic [AGE_BITS-1:0]    src_age;
   logic                   prev_keep;

   assign stale = valid_ff && (age_ff >= stale_age);
   assign keep  = valid_ff && !stale && !($signed(value_ff) < $signed(new_value));

   assign src_keep  = cmd.shift ? up_keep  : keep;
   assign src_value = cmd.shift ? up_value : value_ff;
   assign src_age   = cmd.shift ? up_age   : age_ff;
   // the new sample lands right behind the last surviving entry
   assign prev_keep = HEAD ? 1'b1 : (cmd.shift ? keep : down_keep);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      age_in   = age_ff;
      priority if (cmd.step) begin
         priority if (cmd.restart) begin
            valid_in = HEAD;
            value_in = new_value;
            age_in   = '0;
         end else if (src_keep) begin
            valid_in = 1'b1;
            value_in = src_value;
            age_in   = src_age + AGE_BITS'(1);
         end else if (prev_keep) begin
            valid_in = 1'b1;
            value_in = new_value;
            age_in   = '0;
         end else begin
            valid_in = 1'b0;
         end
      end else if (cmd.shift) begin
         // drop the head only, ages stay relative to the pending sample
         valid_in = up_valid;
         value_in = up_value;
         age_in   = up_age;
      end else begin
         // hold
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      age_ff   <= age_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign age   = age_ff;

endmodule

// ===== sv/sliding_window_maximum_unit.sv =====
// -----------------------------------------------------------------------------
// Sliding window maximum unit
// Running maximum of the last window_size signed samples, kept as a
// monotonic deque spread over a chain of candidate cells.
// -----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample per transaction, tuser set starts a new
//   sequence. rsp_* carries the window maximum; no result is sent until
//   window_size samples of the current sequence have arrived.
//   csr_* writes the window size (0 acts as 1, values above MAX_WINDOW act
//   as MAX_WINDOW); write it only while the unit is idle.
// Timing:
//   A sample is held in the input register; when it steps, the chain updates
//   and loads the output register, raising rsp_tvalid. One sample per cycle
//   is sustained while results are taken; each aged-out head entry beyond the
//   first after a window shrink is dropped by a shift that holds the sample.
// Reset:
//   Synchronous. The chain is empty, the window size is 1 and samples are
//   taken right after reset; no clearing pass is needed.
// Stall:
//   A result is held on rsp_* until taken; one more sample is buffered,
//   then req_tready drops.
// -----------------------------------------------------------------------------
module sliding_window_maximum_unit #(
   parameter int MAX_WINDOW  = swmax_pkg::MAX_WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = swmax_pkg::SAMPLE_BITS_DEFAULT,
   localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // req_tdata: [SAMPLE_BITS-1:0] sample, upper bits zero
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [TDATA_BITS-1:0]         req_tdata,
   // req_tuser: [0] starts_sequence
   input  logic                          req_tuser,
   // rsp_tdata: [SAMPLE_BITS-1:0] window_max, upper bits zero
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [TDATA_BITS-1:0]         rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [swmax_pkg::WINDOW_BITS-1:0] csr_window_size
);
   import swmax_pkg::*;

   localparam int N         = MAX_WINDOW;
   localparam int AGE_BITS  = (N > 1) ? $clog2(N) : 1;
   localparam int SEEN_BITS = $clog2(N + 1);
   localparam int KW        = (SEEN_BITS > WINDOW_BITS) ? SEEN_BITS : WINDOW_BITS;

   // configuration
   logic [SEEN_BITS-1:0]   win_ff, win_in;
   logic [AGE_BITS-1:0]    stale_age_ff, stale_age_in;
   logic [KW-1:0]          win_ext, win_eff;

   // input register
   logic                   pend_valid_ff, pend_valid_in;
   logic [SAMPLE_BITS-1:0] pend_value_ff;
   logic                   pend_sos_ff;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_value_ff;

   logic [SEEN_BITS-1:0]   seen_ff, seen_in, seen_next;

   // chain taps, entry N is the empty slot past the tail
   logic [N:0]             valid_vec;
   logic [N:0]             keep_vec;
   logic [N:0]             stale_vec;
   logic [SAMPLE_BITS-1:0] cell_value [N+1];
   logic [AGE_BITS-1:0]    cell_age   [N+1];
   logic [N-1:0]           down_keep;

   cell_cmd_type           cmd;
   logic                   need_shift;
   logic                   out_free;
   logic                   step;
   logic                   emit;
   logic                   src0_keep;
   logic [SAMPLE_BITS-1:0] src0_value;
   logic [SAMPLE_BITS-1:0] front_value;

   // ---------------------------------------------------------------------
   // Configuration
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      win_ext = KW'(csr_window_size);
      priority if (win_ext == '0) begin
         win_eff = KW'(1);
      end else if (win_ext > KW'(N)) begin
         win_eff = KW'(N);
      end else begin
         win_eff = win_ext;
      end
      win_in       = SEEN_BITS'(win_eff);
      stale_age_in = AGE_BITS'(win_eff - KW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= SEEN_BITS'(1);
         stale_age_ff <= '0;
      end else if (csr_valid) begin
         win_ff       <= win_in;
         stale_age_ff <= stale_age_in;
      end
   end

   // ---------------------------------------------------------------------
   // Control
   // ---------------------------------------------------------------------
   // two aged-out entries at the head: drop one and hold the sample
   assign need_shift = pend_valid_ff && !pend_sos_ff && stale_vec[0] && stale_vec[1];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = pend_valid_ff && !need_shift && out_free;
   assign req_tready = !pend_valid_ff || step;

   always_comb begin
      cmd.step    = step;
      cmd.shift   = need_shift || (step && stale_vec[0]);
      cmd.restart = pend_sos_ff;
   end

   assign pend_valid_in = req_tready ? req_tvalid : pend_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         pend_value_ff <= req_tdata[SAMPLE_BITS-1:0];
         pend_sos_ff   <= req_tuser;
      end
   end

   always_comb begin
      priority if (pend_sos_ff) begin
         seen_next = SEEN_BITS'(1);
      end else if (seen_ff < SEEN_BITS'(N)) begin
         seen_next = seen_ff + SEEN_BITS'(1);
      end else begin
         seen_next = seen_ff;
      end
      seen_in = step ? seen_next : seen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // ---------------------------------------------------------------------
   // Cell chain
   // ---------------------------------------------------------------------
   assign valid_vec[N]  = 1'b0;
   assign keep_vec[N]   = 1'b0;
   assign stale_vec[N]  = 1'b0;
   assign cell_value[N] = '0;
   assign cell_age[N]   = '0;
   assign down_keep[0]  = 1'b1;

   for (genvar i = 0; i < N; i++) begin : g_cell
      if (i < N - 1) begin : g_link
         assign down_keep[i+1] = keep_vec[i];
      end

      swmax_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .AGE_BITS    (AGE_BITS),
         .HEAD        (i == 0)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .new_value (pend_value_ff),
         .stale_age (stale_age_ff),
         .up_valid  (valid_vec[i+1]),
         .up_keep   (keep_vec[i+1]),
         .up_value  (cell_value[i+1]),
         .up_age    (cell_age[i+1]),
         .down_keep (down_keep[i]),
         .valid     (valid_vec[i]),
         .value     (cell_value[i]),
         .age       (cell_age[i]),
         .keep      (keep_vec[i]),
         .stale     (stale_vec[i])
      );
   end

   // ---------------------------------------------------------------------
   // Result
   // ---------------------------------------------------------------------
   // head after the step: surviving entry, else the new sample
   assign src0_keep   = cmd.shift ? keep_vec[1]   : keep_vec[0];
   assign src0_value  = cmd.shift ? cell_value[1] : cell_value[0];
   assign front_value = (!pend_sos_ff && src0_keep) ? src0_value : pend_value_ff;

   assign emit = step && (seen_next >= win_ff);

   always_comb begin
      priority if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_value_ff <= front_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_BITS'(rsp_value_ff);

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_valid_prefix : assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + (N+1)'(1))) == '0)
      else $error("occupied cells are not contiguous from the head");

   a_stale_prefix : assert property (@(posedge clock) disable iff (reset)
      (stale_vec & (stale_vec + (N+1)'(1))) == '0)
      else $error("aged-out entries found behind a live entry");

   a_head_order : assert property (@(posedge clock) disable iff (reset)
      valid_vec[1] |-> ($signed(cell_value[0]) >= $signed(cell_value[1])))
      else $error("deque head smaller than its successor");

   a_head_after_step : assert property (@(posedge clock) disable iff (reset)
      step |=> valid_vec[0])
      else $error("chain empty after taking a sample");

endmodule

// ===== sim/sliding_window_maximum_checker.sv =====
// -----------------------------------------------------------------------------
// Sliding window maximum checker
// Watches the sample, result and window-size channels of the unit, keeps
// its own monotonic deque of candidates and compares every result
// transaction against the oldest predicted window maximum.
// -----------------------------------------------------------------------------
module sliding_window_maximum_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   // req_tdata: [31:0] sample
   input  logic [swmax_pkg::SAMPLE_BITS_DEFAULT-1:0] req_tdata,
   // req_tuser: [0] starts_sequence
   input  logic                                 req_tuser,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // rsp_tdata: [31:0] window_max
   input  logic [swmax_pkg::SAMPLE_BITS_DEFAULT-1:0] rsp_tdata,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [swmax_pkg::WINDOW_BITS-1:0]    csr_window_size,
   output int                                   error_count,
   output int                                   pending_count
);

   localparam int SB        = swmax_pkg::SAMPLE_BITS_DEFAULT;
   localparam int MW        = swmax_pkg::MAX_WINDOW_DEFAULT;
   localparam int SLOT_BITS = $clog2(MW);
   localparam int POS_BITS  = SLOT_BITS + 1;
   localparam int PRINT_CAP = 100;

   logic signed [SB-1:0]            cand_value [MW];
   logic [POS_BITS-1:0]             cand_pos [MW];
   logic [SLOT_BITS-1:0]            head_slot;
   logic [POS_BITS-1:0]             cand_count;
   logic [POS_BITS-1:0]             seq_position;
   logic [POS_BITS-1:0]             seq_seen;
   logic [swmax_pkg::WINDOW_BITS-1:0] window_reg;
   logic signed [SB-1:0]            expected_max_q [$];

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_CAP)
         $display("[%0t] ERROR: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic predict_window_max(input logic signed [SB-1:0] sample,
                                     input logic restart);
      logic [POS_BITS-1:0]  win;
      logic [POS_BITS-1:0]  age;
      logic [SLOT_BITS-1:0] tail;
      if (window_reg == 0)
         win = POS_BITS'(1);
      else if (window_reg > MW)
         win = POS_BITS'(MW);
      else
         win = window_reg;
      if (restart) begin
         head_slot    = '0;
         cand_count   = '0;
         seq_position = '0;
         seq_seen     = '0;
      end
      // drop aged-out head entries; positions wrap modulo 2*MW
      while (cand_count != 0) begin
         age = seq_position - cand_pos[head_slot];
         if (age >= win) begin
            head_slot++;
            cand_count--;
         end else begin
            break;
         end
      end
      // remove strictly smaller tail entries, keep equal ones
      while (cand_count != 0) begin
         tail = head_slot + cand_count[SLOT_BITS-1:0] - 1'b1;
         if (cand_value[tail] < sample)
            cand_count--;
         else
            break;
      end
      if (cand_count >= MW) begin
         head_slot++;
         cand_count--;
      end
      tail = head_slot + cand_count[SLOT_BITS-1:0];
      cand_value[tail] = sample;
      cand_pos[tail]   = seq_position;
      cand_count++;
      seq_position++;
      if (seq_seen < MW)
         seq_seen++;
      if (seq_seen >= win)
         expected_max_q.insert(expected_max_q.size(), cand_value[head_slot]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         head_slot    = '0;
         cand_count   = '0;
         seq_position = '0;
         seq_seen     = '0;
         window_reg   = swmax_pkg::WINDOW_RESET;
         error_count  = 0;
         expected_max_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            window_reg = csr_window_size;
         if (req_tvalid && req_tready)
            predict_window_max($signed(req_tdata), req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_max_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result transaction, window_max %0d",
                                         $signed(rsp_tdata)));
            end else begin
               if ($signed(rsp_tdata) !== expected_max_q[0])
                  report_mismatch($sformatf("window_max got %0d expected %0d",
                                            $signed(rsp_tdata), expected_max_q[0]));
               expected_max_q.delete(0);
            end
         end
      end
      pending_count = expected_max_q.size();
   end

endmodule

// ===== sim/sliding_window_maximum_unit_tb.sv =====
// -----------------------------------------------------------------------------
// Sliding window maximum unit testbench
// Drives directed and random sample sequences through the unit under a
// range of window sizes and handshake pressure; the checker instance
// predicts every window maximum and counts mismatches for the verdict.
// -----------------------------------------------------------------------------
module sliding_window_maximum_unit_tb;

   localparam int SB           = swmax_pkg::SAMPLE_BITS_DEFAULT;
   localparam int MW           = swmax_pkg::MAX_WINDOW_DEFAULT;
   localparam int ITEM_TARGET  = 850;
   localparam int PHASE_ITEMS  = 50;
   localparam int SETTLE_CYCLES = 2 * MW + 8;
   localparam int HOLD_CYCLES  = 150;
   localparam int QUIET_LIMIT  = 3000;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [SB-1:0]                     req_tdata;
   logic                              req_tuser;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [SB-1:0]                     rsp_tdata;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [swmax_pkg::WINDOW_BITS-1:0] csr_window_size;

   int error_count;
   int pending_count;
   int idle_pct;
   int stall_pct;
   int hold_requests;
   int cur_window;
   int seq_left;
   int seq_style;
   int items_sent;
   logic signed [SB-1:0] last_value;

   always #5 clock = ~clock;

   sliding_window_maximum_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_window_size (csr_window_size)
   );

   sliding_window_maximum_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_window_size (csr_window_size),
      .error_count     (error_count),
      .pending_count   (pending_count)
   );

   // result receiver: random stalls, plus a long hold-off on request
   initial begin : receiver
      int hold_left;
      int holds_seen;
      hold_left  = 0;
      holds_seen = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("sliding_window_maximum_unit_tb failed");
      $finish;
   end

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic send_sample(input logic signed [SB-1:0] value, input logic first);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   // hold the sender until every result is back and the chain has settled
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_window(input int value);
      csr_valid       <= 1'b1;
      csr_window_size <= value[swmax_pkg::WINDOW_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_window = (value == 0) ? 1 : (value > MW) ? MW : value;
   endtask

   task automatic next_sample(output logic signed [SB-1:0] value, output logic first);
      first = (seq_left == 0);
      if (first) begin
         case ($urandom_range(9))
            0:       seq_left = $urandom_range(150, 260);
            1:       seq_left = $urandom_range(1, 4);
            default: seq_left = $urandom_range(1, 2 * cur_window + 10);
         endcase
         seq_style  = $urandom_range(3);
         last_value = $urandom;
      end
      seq_left--;
      case (seq_style)
         0:       value = $urandom;
         1:       value = $signed($urandom_range(0, 6)) - 3;
         2:       value = last_value - $urandom_range(0, 2);
         default: value = last_value + $urandom_range(0, 2);
      endcase
      case ($urandom_range(19))
         0:       value = {1'b0, {(SB-1){1'b1}}};
         1:       value = {1'b1, {(SB-1){1'b0}}};
         default: ;
      endcase
      last_value = value;
   endtask

   function automatic int pick_window(input int phase);
      case (phase)
         0: return 127;
         1: return 64;
         2: return 65;
         3: return 1;
         4: return 2;
         5: return 0;
         default: ;
      endcase
      case ($urandom_range(7))
         0, 1, 2, 3: return $urandom_range(1, 8);
         4:          return $urandom_range(9, 63);
         5:          return MW;
         6:          return $urandom_range(MW + 1, 127);
         default:    return 0;
      endcase
   endfunction

   initial begin : stimulus
      int                   phase;
      logic signed [SB-1:0] value;
      logic                 first;
      reset           <= 1'b1;
      req_tvalid      <= 1'b0;
      req_tdata       <= '0;
      req_tuser       <= 1'b0;
      csr_valid       <= 1'b0;
      csr_window_size <= '0;
      idle_pct        = 0;
      stall_pct       = 0;
      hold_requests   = 0;
      cur_window      = 1;
      seq_left        = 0;
      seq_style       = 0;
      items_sent      = 0;
      last_value      = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // window of one straight from reset, extremes of the sample range
      send_sample(32'h7fff_ffff, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'hffff_ffff, 1'b0);
      wait_idle();
      // equal values stay, warm-up, restart in the middle of a sequence
      write_window(3);
      send_sample(5, 1'b1);
      send_sample(5, 1'b0);
      send_sample(3, 1'b0);
      send_sample(7, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(2, 1'b1);
      send_sample(32'h7fff_ffff, 1'b0);
      send_sample(1, 1'b0);
      wait_idle();
      // fill a descending deque, then shrink the window mid-sequence
      write_window(8);
      send_sample(9, 1'b1);
      for (int v = 8; v >= 2; v--)
         send_sample(v, 1'b0);
      wait_idle();
      write_window(2);
      send_sample(0, 1'b0);
      send_sample(-5, 1'b0);
      wait_idle();
      write_window(0);
      send_sample(4, 1'b0);
      send_sample(-4, 1'b0);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         wait_idle();
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 60; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 60; end
            default: begin idle_pct = 35; stall_pct = 35; end
         endcase
         write_window(pick_window(phase));
         // long receiver hold-off while samples keep coming
         if (phase == 4)
            hold_requests++;
         repeat (PHASE_ITEMS) begin
            next_sample(value, first);
            send_sample(value, first);
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (error_count == 0)
         $display("sliding_window_maximum_unit_tb passed");
      else
         $display("sliding_window_maximum_unit_tb failed");
      $finish;
   end

endmodule

// ===== files.f =====
sv/swmax_pkg.sv
sv/swmax_cell.sv
sv/sliding_window_maximum_unit.sv
sim/sliding_window_maximum_checker.sv
sim/sliding_window_maximum_unit_tb.sv
